// File: rtl/pcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared widths, register indexes and program codes for the pump cycle
// sequencer.
// ----------------------------------------------------------------------------
package pcs_pkg;

   localparam int TIME_W      = 32;
   localparam int DUR_W       = 20;
   localparam int PROG_W      = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = DUR_W;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PUMP_PROGRAM  = 3'd0,
      REG_FORCE_OFF     = 3'd1,
      REG_FORCE_ON      = 3'd2,
      REG_SPRAY_ON_TIME = 3'd3,
      REG_IDLE_TIME     = 3'd4,
      REG_SOAK_TIME     = 3'd5,
      REG_DRAIN_TIME    = 3'd6
   } csr_index_type;

   localparam logic [PROG_W-1:0] PROG_SPRAY = 2'd1;
   localparam logic [PROG_W-1:0] PROG_FLOOD = 2'd2;

   localparam logic [PROG_W-1:0] RST_PUMP_PROGRAM  = PROG_FLOOD;
   localparam logic [DUR_W-1:0]  RST_SPRAY_ON_TIME = 20'd10;
   localparam logic [DUR_W-1:0]  RST_IDLE_TIME     = 20'd600;
   localparam logic [DUR_W-1:0]  RST_SOAK_TIME     = 20'd20;
   localparam logic [DUR_W-1:0]  RST_DRAIN_TIME    = 20'd60;
   localparam logic [TIME_W-1:0] RST_DRAIN_END     = 32'd1;

endpackage

// File: rtl/pump_cycle_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_cycle_sequencer
// Drives the fill pump, boost relay and drain pump from a stream of time
// ticks and float readings, running a periodic spray or a fill-soak-drain
// program.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_tvalid/req_tready | now_seconds, float_level
//   rsp     | out       | rsp_tvalid/rsp_tready | fill, boost, drain relays
//   csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// one item per cycle while results are taken; the result is registered and offered in the cycle after acceptance.
// the relay and timestamp registers are updated in the same edge that
// accepts an item, through combinational compare logic.
// a stalled result holds the input off; a new item is taken in the cycle
// the pending result leaves.
// synchronous reset restores the register defaults; csr writes always ready.
// ----------------------------------------------------------------------------
module pump_cycle_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] now_seconds, [32] float_level, [39:33] zero
   input  logic [pcs_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] fill_pump_on, [1] boost_on, [2] drain_pump_on, [7:3] zero
   output logic [pcs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pcs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pcs_pkg::CSR_DATA_W-1:0]    csr_data
);
   import pcs_pkg::*;

   logic [PROG_W-1:0] pump_program_ff;
   logic              force_off_ff;
   logic              force_on_ff;
   logic [DUR_W-1:0]  spray_on_time_ff;
   logic [DUR_W-1:0]  idle_time_ff;
   logic [DUR_W-1:0]  soak_time_ff;
   logic [DUR_W-1:0]  drain_time_ff;

   logic [TIME_W-1:0] fill_start_ff, fill_start_in;
   logic [TIME_W-1:0] fill_end_ff, fill_end_in;
   logic [TIME_W-1:0] drain_start_ff, drain_start_in;
   logic [TIME_W-1:0] drain_end_ff, drain_end_in;
   logic              fill_ff, fill_in;
   logic              boost_ff, boost_in;
   logic              drain_ff, drain_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [TIME_W-1:0] now;
   logic              float_high;
   logic              req_accept;
   logic [TIME_W-1:0] spray_lim, idle_lim, soak_lim, drain_lim;

   assign now        = req_tdata[TIME_W-1:0];
   assign float_high = req_tdata[TIME_W];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign spray_lim = {{(TIME_W-DUR_W){1'b0}}, spray_on_time_ff};
   assign idle_lim  = {{(TIME_W-DUR_W){1'b0}}, idle_time_ff};
   assign soak_lim  = {{(TIME_W-DUR_W){1'b0}}, soak_time_ff};
   assign drain_lim = {{(TIME_W-DUR_W){1'b0}}, drain_time_ff};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-3){1'b0}}, drain_ff, boost_ff, fill_ff};

   // relay and timestamp update for one item
   always_comb begin
      fill_start_in  = fill_start_ff;
      fill_end_in    = fill_end_ff;
      drain_start_in = drain_start_ff;
      drain_end_in   = drain_end_ff;
      fill_in        = fill_ff;
      boost_in       = boost_ff;
      drain_in       = drain_ff;
      if (force_off_ff) begin
         fill_in  = 1'b0;
         boost_in = 1'b0;
      end else if (force_on_ff) begin
         if (pump_program_ff == PROG_SPRAY) begin
            fill_in  = 1'b1;
            boost_in = 1'b1;
         end else if (pump_program_ff == PROG_FLOOD) begin
            boost_in = 1'b0;
            fill_in  = !float_high;
         end
      end else if (pump_program_ff == PROG_SPRAY) begin
         if (fill_start_ff != '0) begin
            if ((now - fill_start_ff) >= spray_lim) begin
               fill_start_in = '0;
               fill_end_in   = now;
               fill_in       = 1'b0;
               boost_in      = 1'b0;
            end
         end else if ((now - fill_end_ff) >= idle_lim) begin
            fill_end_in   = '0;
            fill_start_in = now;
            fill_in       = 1'b1;
            boost_in      = 1'b1;
         end
      end else if (pump_program_ff == PROG_FLOOD) begin
         if (fill_ff) begin
            if (!float_high) begin
               fill_in     = 1'b0;
               boost_in    = 1'b0;
               fill_end_in = now;
            end
         end else begin
            // soak over, drain over, idle over, in that order
            if (fill_end_in != '0 && (now - fill_end_in) > soak_lim) begin
               fill_end_in    = '0;
               drain_in       = 1'b1;
               drain_start_in = now;
            end
            if (drain_start_in != '0 && (now - drain_start_in) > drain_lim) begin
               drain_in       = 1'b0;
               drain_start_in = '0;
               drain_end_in   = now;
            end
            if (drain_end_in != '0 && (now - drain_end_in) > idle_lim && float_high) begin
               fill_in       = 1'b1;
               boost_in      = 1'b1;
               fill_start_in = now;
               drain_end_in  = '0;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         fill_start_ff  <= '0;
         fill_end_ff    <= '0;
         drain_start_ff <= '0;
         drain_end_ff   <= RST_DRAIN_END;
         fill_ff        <= 1'b0;
         boost_ff       <= 1'b0;
         drain_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            fill_start_ff  <= fill_start_in;
            fill_end_ff    <= fill_end_in;
            drain_start_ff <= drain_start_in;
            drain_end_ff   <= drain_end_in;
            fill_ff        <= fill_in;
            boost_ff       <= boost_in;
            drain_ff       <= drain_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pump_program_ff  <= RST_PUMP_PROGRAM;
         force_off_ff     <= 1'b0;
         force_on_ff      <= 1'b0;
         spray_on_time_ff <= RST_SPRAY_ON_TIME;
         idle_time_ff     <= RST_IDLE_TIME;
         soak_time_ff     <= RST_SOAK_TIME;
         drain_time_ff    <= RST_DRAIN_TIME;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            REG_PUMP_PROGRAM:  pump_program_ff  <= csr_data[PROG_W-1:0];
            REG_FORCE_OFF:     force_off_ff     <= csr_data[0];
            REG_FORCE_ON:      force_on_ff      <= csr_data[0];
            REG_SPRAY_ON_TIME: spray_on_time_ff <= csr_data;
            REG_IDLE_TIME:     idle_time_ff     <= csr_data;
            REG_SOAK_TIME:     soak_time_ff     <= csr_data;
            REG_DRAIN_TIME:    drain_time_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

endmodule

// File: rtl/pcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_checker
// Port-level checks for the pump cycle sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module pcs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pcs_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // every accepted item produces a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item gave no result");

   // no item is taken while a result is stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item taken over a stalled result");

   // a result without a new item behind it leaves once taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !req_tvalid |=> !rsp_tvalid)
      else $error("result repeated");

   // stalled result holds its relays
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind pump_cycle_sequencer pcs_checker u_pcs_checker (.*);

// File: test/pump_cycle_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_cycle_sequencer_test
// Stream-level check of the pump cycle sequencer. A directed plan walks the
// flood cycle after reset, timestamp wrap, the force controls, the spray
// program with a zero timestamp, the unused programs and the unused register.
// Random phases then run time that mostly steps forward, with random jumps, under
// varied register settings. Every relay item is compared against its planned value
// or an in-bench model while the sender bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module pump_cycle_sequencer_test;
   import pcs_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;
   localparam logic [PROG_W-1:0]      PROG_NONE  = 2'd0;
   localparam logic [PROG_W-1:0]      PROG_SPARE = 2'd3;
   localparam logic [DUR_W-1:0]       SPAN_MAX   = 20'hFFFFF;
   localparam int                     PHASES     = 9;
   localparam int                     PHASE_ITEMS = 104;
   localparam int                     HOLD_CYCLES = 300;

   typedef struct {
      logic                   is_reg;
      logic [CSR_INDEX_W-1:0] idx;
      logic [DUR_W-1:0]       val;
      logic [TIME_W-1:0]      now;
      logic                   flt;
      logic                   typed;
      logic [2:0]             relays;   // drain, boost, fill
   } plan_row_type;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [REQ_DATA_W-1:0]       req_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [RSP_DATA_W-1:0]       rsp_tdata;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]       csr_data;

   // model of the sequencer
   logic [PROG_W-1:0]           cfg_program;
   logic                        cfg_force_off;
   logic                        cfg_force_on;
   logic [DUR_W-1:0]            cfg_spray;
   logic [DUR_W-1:0]            cfg_idle;
   logic [DUR_W-1:0]            cfg_soak;
   logic [DUR_W-1:0]            cfg_drain;
   logic [TIME_W-1:0]           t_fill_start;
   logic [TIME_W-1:0]           t_fill_end;
   logic [TIME_W-1:0]           t_drain_start;
   logic [TIME_W-1:0]           t_drain_end;
   logic                        m_fill;
   logic                        m_boost;
   logic                        m_drain;

   logic [2:0]                  pending_relays [$];
   plan_row_type                plan [$];
   int                          errors;
   int                          burst_left;
   logic                        hold_off_req;
   string                       relay_name [3] = '{"fill_pump_on", "boost_on", "drain_pump_on"};

   pump_cycle_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("FAILURE");
      $finish;
   end

   task automatic reset_model();
      cfg_program   = RST_PUMP_PROGRAM;
      cfg_force_off = 1'b0;
      cfg_force_on  = 1'b0;
      cfg_spray     = RST_SPRAY_ON_TIME;
      cfg_idle      = RST_IDLE_TIME;
      cfg_soak      = RST_SOAK_TIME;
      cfg_drain     = RST_DRAIN_TIME;
      t_fill_start  = '0;
      t_fill_end    = '0;
      t_drain_start = '0;
      t_drain_end   = RST_DRAIN_END;
      m_fill        = 1'b0;
      m_boost       = 1'b0;
      m_drain       = 1'b0;
   endtask

   task automatic step_relays(input logic [TIME_W-1:0] now, input logic float_hi,
                              output logic [2:0] relays);
      logic [TIME_W-1:0] elapsed;
      if (cfg_force_off) begin
         m_fill  = 1'b0;
         m_boost = 1'b0;
      end else if (cfg_force_on) begin
         if (cfg_program == PROG_SPRAY) begin
            m_fill  = 1'b1;
            m_boost = 1'b1;
         end else if (cfg_program == PROG_FLOOD) begin
            m_boost = 1'b0;
            m_fill  = !float_hi;
         end
      end else if (cfg_program == PROG_SPRAY) begin
         if (t_fill_start != 0) begin
            elapsed = now - t_fill_start;
            if (elapsed >= {12'd0, cfg_spray}) begin
               t_fill_start = '0;
               t_fill_end   = now;
               m_fill       = 1'b0;
               m_boost      = 1'b0;
            end
         end else begin
            elapsed = now - t_fill_end;
            if (elapsed >= {12'd0, cfg_idle}) begin
               t_fill_end   = '0;
               t_fill_start = now;
               m_fill       = 1'b1;
               m_boost      = 1'b1;
            end
         end
      end else if (cfg_program == PROG_FLOOD) begin
         if (m_fill) begin
            if (!float_hi) begin
               m_fill     = 1'b0;
               m_boost    = 1'b0;
               t_fill_end = now;
            end
         end else begin
            elapsed = now - t_fill_end;
            if (t_fill_end != 0 && elapsed > {12'd0, cfg_soak}) begin
               t_fill_end    = '0;
               m_drain       = 1'b1;
               t_drain_start = now;
            end
            elapsed = now - t_drain_start;
            if (t_drain_start != 0 && elapsed > {12'd0, cfg_drain}) begin
               m_drain       = 1'b0;
               t_drain_start = '0;
               t_drain_end   = now;
            end
            elapsed = now - t_drain_end;
            if (t_drain_end != 0 && elapsed > {12'd0, cfg_idle} && float_hi) begin
               m_fill       = 1'b1;
               m_boost      = 1'b1;
               t_fill_start = now;
               t_drain_end  = '0;
            end
         end
      end
      relays = {m_drain, m_boost, m_fill};
   endtask

   // park the sender and wait until every relay item is back
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_relays.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [DUR_W-1:0] val);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_PUMP_PROGRAM:  cfg_program   = val[PROG_W-1:0];
         REG_FORCE_OFF:     cfg_force_off = val[0];
         REG_FORCE_ON:      cfg_force_on  = val[0];
         REG_SPRAY_ON_TIME: cfg_spray     = val;
         REG_IDLE_TIME:     cfg_idle      = val;
         REG_SOAK_TIME:     cfg_soak      = val;
         REG_DRAIN_TIME:    cfg_drain     = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_tick(input logic [TIME_W-1:0] now, input logic float_hi,
                            output logic [2:0] relays);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - TIME_W - 1){1'b0}}, float_hi, now};
      do @(posedge clock); while (!req_tready);
      step_relays(now, float_hi, relays);
   endtask

   function automatic plan_row_type item_row(input logic [TIME_W-1:0] now, input logic flt,
                                             input logic typed, input logic [2:0] relays);
      plan_row_type r;
      r.is_reg = 1'b0;
      r.idx    = '0;
      r.val    = '0;
      r.now    = now;
      r.flt    = flt;
      r.typed  = typed;
      r.relays = relays;
      return r;
   endfunction

   function automatic plan_row_type reg_row(input logic [CSR_INDEX_W-1:0] idx,
                                            input logic [DUR_W-1:0] val);
      plan_row_type r;
      r        = item_row('0, 1'b0, 1'b0, 3'b000);
      r.is_reg = 1'b1;
      r.idx    = idx;
      r.val    = val;
      return r;
   endfunction

   function automatic logic [DUR_W-1:0] pick_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return DUR_W'($urandom_range(0, 6));
      if (r < 85) return DUR_W'($urandom_range(0, SPAN_MAX));
      return (r[0]) ? '0 : SPAN_MAX;
   endfunction

   task automatic configure_phase(input int p);
      logic [PROG_W-1:0] prog;
      logic              f_off;
      logic              f_on;
      logic [DUR_W-1:0]  span [4];
      int                r;
      f_off = 1'b0;
      f_on  = 1'b0;
      if (p == 0) begin
         prog = PROG_SPRAY;
         foreach (span[i]) span[i] = '0;
      end else if (p == 1) begin
         prog = PROG_FLOOD;
         foreach (span[i]) span[i] = SPAN_MAX;
      end else if (p == 2) begin
         prog = PROG_SPRAY;
         foreach (span[i]) span[i] = SPAN_MAX;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 40) prog = PROG_SPRAY;
         else if (r < 85) prog = PROG_FLOOD;
         else prog = r[0] ? PROG_NONE : PROG_SPARE;
         f_off = ($urandom_range(0, 7) == 0);
         f_on  = ($urandom_range(0, 5) == 0);
         foreach (span[i]) span[i] = pick_span();
      end
      write_reg(REG_PUMP_PROGRAM, {{(DUR_W - PROG_W){1'b0}}, prog});
      write_reg(REG_FORCE_OFF, {{(DUR_W - 1){1'b0}}, f_off});
      write_reg(REG_FORCE_ON, {{(DUR_W - 1){1'b0}}, f_on});
      write_reg(REG_SPRAY_ON_TIME, span[0]);
      write_reg(REG_IDLE_TIME, span[1]);
      write_reg(REG_SOAK_TIME, span[2]);
      write_reg(REG_DRAIN_TIME, span[3]);
   endtask

   // receiver: segments of random stall patterns, plus a long hold-off on request
   initial begin : relay_sink
      int seg;
      int mode;
      forever begin
         seg  = $urandom_range(1, 40);
         mode = $urandom_range(0, 3);
         repeat (seg) begin
            @(negedge clock);
            if (hold_off_req) begin
               hold_off_req = 1'b0;
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
            end else begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= 1'($urandom_range(0, 1));
                  2: rsp_tready <= ($urandom_range(0, 3) == 0);
                  default: rsp_tready <= ($urandom_range(0, 5) != 0);
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin : relay_check
      logic [2:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_relays.size() == 0) begin
            $display("%0t: unexpected relay item, expected none, got %b", $time,
                     rsp_tdata[2:0]);
            errors++;
         end else begin
            want = pending_relays.pop_front();
            for (int i = 0; i < 3; i++) begin
               if (want[i] !== rsp_tdata[i]) begin
                  $display("%0t: %s expected %b, got %b", $time, relay_name[i],
                           want[i], rsp_tdata[i]);
                  errors++;
               end
            end
         end
      end
   end

   initial begin : stimulus
      logic [2:0]        want;
      logic [TIME_W-1:0] now;
      logic              flt;
      int                pick;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      errors       = 0;
      burst_left   = 0;
      hold_off_req = 1'b0;
      reset_model();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // flood cycle from reset: fill, float drop, soak, drain, idle, refill
      plan.push_back(item_row(32'd0, 1'b1, 1'b1, 3'b011));
      plan.push_back(item_row(32'd5, 1'b1, 1'b1, 3'b011));
      plan.push_back(item_row(32'd10, 1'b0, 1'b1, 3'b000));
      plan.push_back(item_row(32'd31, 1'b0, 1'b1, 3'b100));
      plan.push_back(item_row(32'd92, 1'b0, 1'b1, 3'b000));
      plan.push_back(item_row(32'd693, 1'b1, 1'b1, 3'b011));
      // stop at the top timestamp, soak across the wrap
      plan.push_back(item_row(32'hFFFF_FFFF, 1'b0, 1'b1, 3'b000));
      plan.push_back(item_row(32'd20, 1'b0, 1'b1, 3'b100));
      // forces leave the drain alone
      plan.push_back(reg_row(REG_FORCE_ON, 20'd1));
      plan.push_back(item_row(32'd21, 1'b1, 1'b1, 3'b100));
      plan.push_back(item_row(32'd22, 1'b0, 1'b1, 3'b101));
      plan.push_back(reg_row(REG_FORCE_OFF, 20'd1));
      plan.push_back(item_row(32'd23, 1'b0, 1'b1, 3'b100));
      plan.push_back(reg_row(REG_FORCE_OFF, 20'd0));
      plan.push_back(reg_row(REG_PUMP_PROGRAM, {18'd0, PROG_SPRAY}));
      plan.push_back(item_row(32'd24, 1'b1, 1'b1, 3'b111));
      // spray with zero times and a zero timestamp
      plan.push_back(reg_row(REG_FORCE_ON, 20'd0));
      plan.push_back(reg_row(REG_SPRAY_ON_TIME, 20'd0));
      plan.push_back(reg_row(REG_IDLE_TIME, 20'd0));
      plan.push_back(item_row(32'd0, 1'b1, 1'b0, 3'b000));
      plan.push_back(item_row(32'd0, 1'b0, 1'b0, 3'b000));
      plan.push_back(item_row(32'd5, 1'b1, 1'b0, 3'b000));
      // unused programs hold the relays
      plan.push_back(reg_row(REG_PUMP_PROGRAM, {18'd0, PROG_NONE}));
      plan.push_back(item_row(32'd6, 1'b1, 1'b0, 3'b000));
      plan.push_back(reg_row(REG_PUMP_PROGRAM, {18'd0, PROG_SPARE}));
      plan.push_back(item_row(32'd7, 1'b0, 1'b0, 3'b000));
      plan.push_back(reg_row(REG_UNUSED, SPAN_MAX));
      plan.push_back(reg_row(REG_PUMP_PROGRAM, {18'd0, PROG_FLOOD}));
      plan.push_back(reg_row(REG_SOAK_TIME, SPAN_MAX));
      plan.push_back(reg_row(REG_DRAIN_TIME, SPAN_MAX));
      plan.push_back(reg_row(REG_IDLE_TIME, SPAN_MAX));
      plan.push_back(item_row(32'd8, 1'b1, 1'b0, 3'b000));
      plan.push_back(item_row(32'hFFFF_FFFF, 1'b0, 1'b0, 3'b000));

      foreach (plan[i]) begin
         if (plan[i].is_reg) begin
            write_reg(plan[i].idx, plan[i].val);
         end else begin
            send_tick(plan[i].now, plan[i].flt, want);
            pending_relays.push_back(plan[i].typed ? plan[i].relays : want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         configure_phase(p);
         now = ($urandom_range(0, 1) == 1) ? 32'($urandom)
                                           : 32'hFFFF_FFFF - $urandom_range(0, 300);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ((p == 2 || p == 6) && n == 30) hold_off_req = 1'b1;
            if (p == 4 && n == 50) settle();
            pick = $urandom_range(0, 99);
            if (pick < 80) now = now + $urandom_range(0, 4);
            else if (pick < 95) now = now + $urandom_range(0, 1 << 21);
            else if (pick < 98) now = $urandom;
            else now = '0;
            flt = ($urandom_range(0, 9) < 7);
            send_tick(now, flt, want);
            pending_relays.push_back(want);
         end
      end

      settle();
      repeat (4) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
